// ----- rtl/core/spoc_pkg.sv -----
// Package for the split-output PID controller: beat types, the configuration
// record, register indexes, sequencer state codes and fixed-point widths.
// No dependencies; every other file in rtl/core imports it.
package spoc_pkg;

	// Input and output beats.
	typedef struct packed {
		logic [15:0] measurement;
		logic [15:0] target;
		logic        auto_on;
	} sample_t;

	typedef struct packed {
		logic [15:0] coarse_out;
		logic [15:0] fine_out;
		logic        updated;
	} result_t;

	// Configuration registers as one record.
	typedef struct packed {
		logic signed [31:0] prop_gain;
		logic signed [31:0] integ_gain;
		logic signed [31:0] deriv_gain;
		logic        [15:0] amp_scale;
		logic        [15:0] split_factor;
		logic signed [15:0] limit_low;
		logic signed [15:0] limit_high;
	} cfg_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMP_SCALE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_FACTOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH   = 3'd6;

	localparam cfg_t CFG_RESET = '{
		prop_gain:    32'sd1678,
		integ_gain:   32'sd0,
		deriv_gain:   32'sd0,
		amp_scale:    16'd256,
		split_factor: 16'd11136,
		limit_low:    16'sd0,
		limit_high:   16'sd3000
	};

	// Sequencer states.
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_PREP  = 4'd1;
	localparam logic [ST_W-1:0] ST_KI    = 4'd2;
	localparam logic [ST_W-1:0] ST_INT   = 4'd3;
	localparam logic [ST_W-1:0] ST_KP    = 4'd4;
	localparam logic [ST_W-1:0] ST_KD0   = 4'd5;
	localparam logic [ST_W-1:0] ST_KD    = 4'd6;
	localparam logic [ST_W-1:0] ST_PD    = 4'd7;
	localparam logic [ST_W-1:0] ST_SUM   = 4'd8;
	localparam logic [ST_W-1:0] ST_RAW   = 4'd9;
	localparam logic [ST_W-1:0] ST_SPLIT = 4'd10;
	localparam logic [ST_W-1:0] ST_RND   = 4'd11;
	localparam logic [ST_W-1:0] ST_OUT   = 4'd12;

	typedef struct packed {
		logic [ST_W-1:0] state;
		logic            load_out;
	} seq_ctrl_t;

	// Fixed-point widths.
	localparam int FRAC_W  = 24;            // Q.24 fraction
	localparam int IP_W    = 16;            // integer part of the integrator
	localparam int FIX_W   = IP_W + FRAC_W; // a 16-bit limit in Q.24
	localparam int INTEG_W = 48;
	localparam int MUL_A_W = 41;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ISUM_W  = MUL_P_W + 1;
	localparam int ACC_W   = MUL_P_W + 2;
	localparam int RAW_W   = ACC_W - FRAC_W;
	localparam int FI_W    = FRAC_W + 1;
	localparam int RESID_W = FRAC_W + 2;
	localparam int RND_W   = 44;
	localparam int STERM_W = RND_W - 32;
	localparam int FINE_W  = 17;

	localparam logic [15:0]       FINE_MANUAL = 16'd2000;
	localparam logic [RND_W-1:0]  RND_HALF    = 44'h0_8000_0000;

endpackage

// ----- rtl/core/spoc_mul.sv -----
// Shared signed multiplier with its product register.
// Depends on spoc_pkg for operand and product widths.
module spoc_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [spoc_pkg::MUL_A_W-1:0]  a,
	input  logic signed [spoc_pkg::MUL_B_W-1:0]  b,
	output logic signed [spoc_pkg::MUL_P_W-1:0]  p_q
);
	import spoc_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// ----- rtl/core/spoc_ctrl.sv -----
// Sequencer that steps one sample through the shared multiplier schedule.
// Depends on spoc_pkg for state codes and the control record.
module spoc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  auto_on,
	input  logic                  out_free,
	output logic                  busy,
	output spoc_pkg::seq_ctrl_t   ctrl
);
	import spoc_pkg::*;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_PREP;
			ST_PREP:  state_d = auto_on ? ST_KI : ST_OUT;
			ST_KI:    state_d = ST_INT;
			ST_INT:   state_d = ST_KP;
			ST_KP:    state_d = ST_KD0;
			ST_KD0:   state_d = ST_KD;
			ST_KD:    state_d = ST_PD;
			ST_PD:    state_d = ST_SUM;
			ST_SUM:   state_d = ST_RAW;
			ST_RAW:   state_d = ST_SPLIT;
			ST_SPLIT: state_d = ST_RND;
			ST_RND:   state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign ctrl.state    = state_q;
	assign ctrl.load_out = (state_q == ST_OUT) && out_free;

endmodule

// ----- rtl/core/spoc_dp.sv -----
// Datapath: controller state, operand selection for the shared multiplier,
// accumulator, rounding and clamps. Depends on spoc_pkg and spoc_mul.
module spoc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spoc_pkg::seq_ctrl_t   ctrl,
	input  spoc_pkg::cfg_t        cfg,
	input  spoc_pkg::sample_t     smp,
	output spoc_pkg::result_t     res
);
	import spoc_pkg::*;

	// Controller state.
	logic signed [INTEG_W-1:0] integ_q;
	logic        [15:0]        prev_q;
	logic                      was_auto_q;
	logic signed [15:0]        held_q;

	// Working registers for one sample.
	logic signed [MUL_B_W-1:0] err_q;
	logic signed [MUL_B_W-1:0] din_q;
	logic        [IP_W-1:0]    ip_q;
	logic signed [FI_W-1:0]    fi_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [RAW_W-1:0]   raw_q;
	logic signed [RESID_W-1:0] resid_q;
	logic signed [15:0]        coarse_q;
	logic signed [STERM_W-1:0] sterm_q;

	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [MUL_A_W-1:0] k_gain;
	logic signed [MUL_B_W-1:0] amp_b;

	logic signed [FIX_W-1:0]   lo_fix;
	logic signed [FIX_W-1:0]   hi_fix;
	logic signed [FIX_W-1:0]   held_fix;
	logic signed [FIX_W-1:0]   ip_fix;
	logic signed [ISUM_W-1:0]  isum;
	logic signed [ISUM_W-1:0]  isum_clamped;
	logic                      ip_inc;
	logic                      s_inc;
	logic signed [FI_W-1:0]    s_frac;
	logic        [RND_W-1:0]   rnd_t;
	logic                      rnd_inc;
	logic signed [15:0]        coarse_c;
	logic signed [FINE_W-1:0]  fine_sum;
	logic signed [15:0]        fine_c;

	// An effective gain is the amp-scaled product floored by 2^8.
	assign k_gain = prod_q[MUL_A_W+7:8];
	assign amp_b  = {1'b0, cfg.amp_scale};

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (ctrl.state)
			ST_PREP: begin
				mul_a = {{(MUL_A_W-32){cfg.integ_gain[31]}}, cfg.integ_gain};
				mul_b = amp_b;
			end
			ST_KI: begin
				mul_a = k_gain;
				mul_b = err_q;
			end
			ST_INT: begin
				mul_a = {{(MUL_A_W-32){cfg.prop_gain[31]}}, cfg.prop_gain};
				mul_b = amp_b;
			end
			ST_KP: begin
				mul_a = k_gain;
				mul_b = err_q;
			end
			ST_KD0: begin
				mul_a = {{(MUL_A_W-32){cfg.deriv_gain[31]}}, cfg.deriv_gain};
				mul_b = amp_b;
			end
			ST_KD: begin
				mul_a = k_gain;
				mul_b = din_q;
			end
			ST_SPLIT: begin
				mul_a = MUL_A_W'(resid_q);
				mul_b = {1'b0, cfg.split_factor};
			end
			default: mul_en = 1'b0;
		endcase
	end

	spoc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign lo_fix   = {cfg.limit_low, {FRAC_W{1'b0}}};
	assign hi_fix   = {cfg.limit_high, {FRAC_W{1'b0}}};
	assign held_fix = {held_q, {FRAC_W{1'b0}}};
	assign ip_fix   = {ip_q, {FRAC_W{1'b0}}};

	// Integrator update, clamped high first and then low.
	assign isum = ISUM_W'(integ_q) + ISUM_W'(prod_q);
	always_comb begin
		if (isum > ISUM_W'(hi_fix)) begin
			isum_clamped = ISUM_W'(hi_fix);
		end else if (isum < ISUM_W'(lo_fix)) begin
			isum_clamped = ISUM_W'(lo_fix);
		end else begin
			isum_clamped = isum;
		end
	end

	// Truncation toward zero: a negative value with a nonzero fraction
	// steps its floor up by one.
	assign ip_inc = integ_q[INTEG_W-1] && (|integ_q[FRAC_W-1:0]);
	assign s_inc  = acc_q[ACC_W-1] && (|acc_q[FRAC_W-1:0]);
	assign s_frac = {s_inc, acc_q[FRAC_W-1:0]};

	assign rnd_t   = prod_q[RND_W-1:0] + RND_HALF;
	assign rnd_inc = rnd_t[RND_W-1] && (|rnd_t[31:0]);

	always_comb begin
		if (raw_q > RAW_W'(cfg.limit_high)) begin
			coarse_c = cfg.limit_high;
		end else if (raw_q < RAW_W'(cfg.limit_low)) begin
			coarse_c = cfg.limit_low;
		end else begin
			coarse_c = raw_q[15:0];
		end
	end

	assign fine_sum = FINE_W'(signed'({1'b0, FINE_MANUAL})) + FINE_W'(sterm_q);
	always_comb begin
		if (fine_sum > FINE_W'(cfg.limit_high)) begin
			fine_c = cfg.limit_high;
		end else if (fine_sum < FINE_W'(cfg.limit_low)) begin
			fine_c = cfg.limit_low;
		end else begin
			fine_c = fine_sum[15:0];
		end
	end

	always_comb begin
		if (smp.auto_on) begin
			res.coarse_out = coarse_q;
			res.fine_out   = -fine_c;
			res.updated    = 1'b1;
		end else begin
			res.coarse_out = held_q;
			res.fine_out   = FINE_MANUAL;
			res.updated    = 1'b0;
		end
	end

	// Controller state: bumpless load on the manual-to-auto edge, commit of
	// the held output and previous sample when an auto result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_q     <= '0;
			was_auto_q <= 1'b0;
			held_q     <= '0;
		end else begin
			if (ctrl.state == ST_PREP && smp.auto_on && !was_auto_q) begin
				integ_q <= INTEG_W'(held_fix);
			end
			if (ctrl.state == ST_INT) begin
				integ_q <= INTEG_W'(isum_clamped);
			end
			if (ctrl.load_out) begin
				was_auto_q <= smp.auto_on;
				if (smp.auto_on) begin
					held_q <= coarse_q;
					prev_q <= smp.measurement;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.state)
			ST_PREP: begin
				err_q <= {1'b0, smp.target} - {1'b0, smp.measurement};
				if (was_auto_q) begin
					din_q <= {1'b0, smp.measurement} - {1'b0, prev_q};
				end else begin
					din_q <= '0;
				end
			end
			ST_KP:    ip_q <= integ_q[FIX_W-1:FRAC_W] + {{(IP_W-1){1'b0}}, ip_inc};
			ST_KD0: begin
				acc_q <= ACC_W'(prod_q);
				fi_q  <= integ_q[FI_W-1:0] - {ip_q[0], {FRAC_W{1'b0}}};
			end
			ST_PD:    acc_q <= acc_q - ACC_W'(prod_q);
			ST_SUM:   acc_q <= acc_q + ACC_W'(ip_fix);
			ST_RAW: begin
				raw_q   <= acc_q[ACC_W-1:FRAC_W] + {{(RAW_W-1){1'b0}}, s_inc};
				resid_q <= RESID_W'(fi_q) + RESID_W'(s_frac);
			end
			ST_SPLIT: coarse_q <= coarse_c;
			ST_RND:   sterm_q <= rnd_t[RND_W-1:32] + {{(STERM_W-1){1'b0}}, rnd_inc};
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/split_output_pid_controller.sv -----
// Split-output PID controller, derivative on measurement, one sample a beat.
// One sample is taken at a time: the input side stalls while an auto sample
// runs the seven products that share one 41x17 multiplier, or a manual one
// goes from prep straight to output, until its result is loaded. Reset loads
// the register defaults, clears the integrator, held output, previous sample
// and auto flag, and leaves no result pending.
module split_output_pid_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  spoc_pkg::sample_t                    sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output spoc_pkg::result_t                    result,
	input  logic                                 cfg_write,
	input  logic [spoc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spoc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import spoc_pkg::*;

	cfg_t      cfg_q;
	sample_t   sample_q;
	result_t   res;
	seq_ctrl_t ctrl;
	logic      busy;
	logic      start;
	logic      out_free;
	logic      result_valid_q;

	// Configuration writes. The narrow registers take the low bits of the
	// data word; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data;
				REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data;
				REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data;
				REG_AMP_SCALE:    cfg_q.amp_scale    <= cfg_data[15:0];
				REG_SPLIT_FACTOR: cfg_q.split_factor <= cfg_data[15:0];
				REG_LIMIT_LOW:    cfg_q.limit_low    <= cfg_data[15:0];
				REG_LIMIT_HIGH:   cfg_q.limit_high   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The input side is open whenever the sequencer is idle, even while a
	// finished result still waits in the output register.
	assign sample_stall = busy;
	assign start        = sample_valid && !busy;

	// The sample is captured once and held for the whole sequence.
	always_ff @(posedge clk) begin
		if (start) begin
			sample_q <= sample;
		end
	end

	// The output register can take a new result when it is empty or its
	// current beat leaves at this edge.
	assign out_free = !result_valid_q || !result_stall;

	spoc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.auto_on  (sample_q.auto_on),
		.out_free (out_free),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	spoc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg_q),
		.smp    (sample_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			result <= res;
		end
	end

	assign result_valid = result_valid_q;

	// An accepted sample closes the input side on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> sample_stall)
		else $error("input side still open after a sample beat was accepted");

	// A new result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (!result_valid_q || !result_stall))
		else $error("result register overwritten while its beat was stalled");

	// With ordered limits an auto result's big output lies within them.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out && sample_q.auto_on && (cfg_q.limit_low <= cfg_q.limit_high)
		|=> ($signed(result.coarse_out) <= $past(cfg_q.limit_high))
			&& ($signed(result.coarse_out) >= $past(cfg_q.limit_low)))
		else $error("auto big output outside the limits");

	// A manual sample gives the fixed small output and no update flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out && !sample_q.auto_on
		|=> !result.updated && (result.fine_out == FINE_MANUAL))
		else $error("manual result carries computed fields");

endmodule
